/* rtl/assert_macros.svh */
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define CRCFB_ASSERT(lbl, clk_i, rst_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (prop)) \
    else $error("crcfb assertion failed");

// Check that a trigger is followed in the next cycle by an outcome.
`define CRCFB_ASSERT_NEXT(lbl, clk_i, rst_i, trig, outc) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (trig) |=> (outc)) \
    else $error("crcfb assertion failed");

`endif

/* rtl/crcfb_pkg.sv */
// Types, constants and the CRC byte update shared by the framer modules.
package crcfb_pkg;

  // Byte position that marks a complete frame
  localparam logic [3:0] POS_DONE = 4'd15;
  // Most result items one input item can produce
  localparam int RES_MAX = 3;
  // Result queue depth
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Frame modes latched at frame start
  localparam logic MODE_TX = 1'b0;
  localparam logic MODE_RX = 1'b1;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        frame_done;
    logic        crc_match;
    logic [15:0] crc_word;
  } crcfb_result_t;

  typedef struct packed {
    logic not_empty;
    logic has_room;
  } crcfb_qstat_t;

  // One byte-wise CRC-16 update; crc holds high byte in 15:8, low byte in 7:0
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] d);
    logic [7:0] t;
    logic [7:0] lo;
    logic [7:0] hi;
    t  = d ^ crc[7:0];
    t  = t ^ (t << 4);
    lo = crc[15:8] ^ (t << 3) ^ (t >> 4);
    hi = t ^ (t >> 5);
    return {hi, lo};
  endfunction

endpackage

/* rtl/crcfb_rfifo.sv */
// Result queue: takes up to three result items per cycle, delivers one per cycle.
`include "assert_macros.svh"
module crcfb_rfifo
  import crcfb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_cnt,
  input  crcfb_result_t       push_data [RES_MAX],
  input  logic                pop,
  output crcfb_result_t       head,
  output crcfb_qstat_t        stat
);

  crcfb_result_t     mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;

  // Track occupancy
  always_comb begin
    count_next = count + QCNT_W'(push_cnt) - QCNT_W'(pop);
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QPTR_W'(push_cnt);
      rptr  <= rptr + QPTR_W'(pop);
      count <= count_next;
    end
  end

  // Store pushed items in order
  always_ff @(posedge clk) begin
    for (int k = 0; k < RES_MAX; k++) begin
      if (2'(k) < push_cnt) begin
        mem[wptr + QPTR_W'(k)] <= push_data[k];
      end
    end
  end

  assign head           = mem[rptr];
  assign stat.not_empty = (count != '0);
  assign stat.has_room  = (count <= QCNT_W'(QDEPTH - RES_MAX));

  `CRCFB_ASSERT(a_count_bound, clk, rst, count <= QCNT_W'(QDEPTH))
  `CRCFB_ASSERT(a_no_overflow, clk, rst, (push_cnt == 2'd0) || (QCNT_W'(push_cnt) + count - QCNT_W'(pop) <= QCNT_W'(QDEPTH)))
  `CRCFB_ASSERT(a_no_underflow, clk, rst, !pop || stat.not_empty)
  `CRCFB_ASSERT_NEXT(a_drain, clk, rst, pop && (count == QCNT_W'(1)) && (push_cnt == 2'd0), count == '0)

endmodule

/* rtl/crc16_frame_builder_checker.sv */
// Top level of the CRC-16 (X.25) frame builder and reply checker.
//
// Input channel s_axis: one frame byte per item. tdata holds byte_value; tuser bit 0 is
// command (0 build a transmit frame, 1 check a received reply), bit 1 is frame_start,
// which restarts the byte position and the CRC and latches the command.
// Transmit: each of TX_PAYLOAD_BYTES bytes comes back as one result item; after the last
// one the inverted CRC low byte and high byte follow, the high byte marked with tlast.
// Receive: RX_PAYLOAD_BYTES payload bytes and the CRC low byte give no result; the CRC
// high byte gives one item with tlast, the match flag and the computed CRC word.
// Bytes after a complete frame are dropped until the next frame_start.
// Output channel m_axis: results leave a four-entry queue, one item per cycle, the first
// in the cycle after its input item is accepted. An input item is accepted in every cycle
// while the queue holds at most one item, so one-result items stream at one per cycle;
// the byte that closes a transmit frame gives three result items.
// When the receiver stalls, results wait in the queue and s_axis_tready falls once it
// holds two items. Reset empties the queue and starts a fresh transmit frame.
`include "assert_macros.svh"
module crc16_frame_builder_checker
  import crcfb_pkg::*;
#(
  parameter int TX_PAYLOAD_BYTES = 8,
  parameter int RX_PAYLOAD_BYTES = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]  s_axis_tuser,   // [0] command, [1] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] crc_word
  output logic [1:0]  m_axis_tuser,   // [0] byte_present, [1] crc_match
  output logic        m_axis_tlast    // frame_done
);

  logic [15:0]   crc;
  logic [3:0]    pos;
  logic          mode;
  logic [7:0]    rx_crc_low;
  logic [15:0]   crc_next;
  logic [3:0]    pos_next;
  logic          mode_next;
  logic [7:0]    rx_crc_low_next;

  logic          accept;
  logic          pop;
  logic [7:0]    din;
  logic          frame_start;
  logic [15:0]   crc_eff;
  logic [3:0]    pos_eff;
  logic          mode_eff;
  logic [15:0]   crc_fed;
  logic [15:0]   word_tx;
  logic [15:0]   word_rx;
  logic          tx_last;
  logic [1:0]    push_cnt;
  crcfb_result_t push_data [RES_MAX];
  crcfb_result_t head;
  crcfb_qstat_t  stat;

  assign din         = s_axis_tdata;
  assign frame_start = s_axis_tuser[1];
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign pop         = m_axis_tvalid && m_axis_tready;

  // Restart the frame on frame_start
  always_comb begin
    crc_eff  = frame_start ? 16'hFFFF : crc;
    pos_eff  = frame_start ? 4'd0 : pos;
    mode_eff = frame_start ? s_axis_tuser[0] : mode;
    crc_fed  = crc_feed(crc_eff, din);
    word_tx  = ~crc_fed;
    word_rx  = ~crc_eff;
    tx_last  = ({1'b0, pos_eff} + 5'd1) >= 5'(TX_PAYLOAD_BYTES);
  end

  // Frame step: next state and result items
  always_comb begin
    crc_next        = crc;
    pos_next        = pos;
    mode_next       = mode;
    rx_crc_low_next = rx_crc_low;
    push_cnt        = 2'd0;
    for (int k = 0; k < RES_MAX; k++) begin
      push_data[k] = '0;
    end
    if (accept) begin
      crc_next  = crc_eff;
      pos_next  = pos_eff;
      mode_next = mode_eff;
      if (pos_eff != POS_DONE) begin
        if (mode_eff == MODE_TX) begin
          crc_next                  = crc_fed;
          push_data[0].out_byte     = din;
          push_data[0].byte_present = 1'b1;
          if (tx_last) begin
            push_data[1].out_byte     = word_tx[7:0];
            push_data[1].byte_present = 1'b1;
            push_data[2].out_byte     = word_tx[15:8];
            push_data[2].byte_present = 1'b1;
            push_data[2].frame_done   = 1'b1;
            push_data[2].crc_word     = word_tx;
            push_cnt                  = 2'd3;
            pos_next                  = POS_DONE;
          end else begin
            push_cnt = 2'd1;
            pos_next = pos_eff + 4'd1;
          end
        end else if ({1'b0, pos_eff} < 5'(RX_PAYLOAD_BYTES)) begin
          crc_next = crc_fed;
          pos_next = pos_eff + 4'd1;
        end else if ({1'b0, pos_eff} == 5'(RX_PAYLOAD_BYTES)) begin
          rx_crc_low_next = din;
          pos_next        = pos_eff + 4'd1;
        end else begin
          push_data[0].frame_done = 1'b1;
          push_data[0].crc_match  = ({din, rx_crc_low} == word_rx);
          push_data[0].crc_word   = word_rx;
          push_cnt                = 2'd1;
          pos_next                = POS_DONE;
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc        <= 16'hFFFF;
      pos        <= 4'd0;
      mode       <= MODE_TX;
      rx_crc_low <= 8'd0;
    end else begin
      crc        <= crc_next;
      pos        <= pos_next;
      mode       <= mode_next;
      rx_crc_low <= rx_crc_low_next;
    end
  end

  crcfb_rfifo u_rfifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  assign s_axis_tready = stat.has_room;
  assign m_axis_tvalid = stat.not_empty;
  assign m_axis_tdata  = {head.crc_word, head.out_byte};
  assign m_axis_tuser  = {head.crc_match, head.byte_present};
  assign m_axis_tlast  = head.frame_done;

  `CRCFB_ASSERT_NEXT(a_done_frame_holds, clk, rst, accept && !frame_start && (pos == POS_DONE), $stable(crc) && $stable(pos) && $stable(mode))
  `CRCFB_ASSERT(a_tx_no_match, clk, rst, !(m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1]))
  `CRCFB_ASSERT(a_word_only_at_end, clk, rst, !m_axis_tvalid || m_axis_tlast || (m_axis_tdata[23:8] == 16'd0))

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the CRC-16 frame builder and reply checker.
`timescale 1ns / 100ps

module tb_top;
  import crcfb_pkg::*;

  localparam int TX_BYTES   = 8;
  localparam int RX_BYTES   = 6;
  localparam int N_RANDOM   = 200;
  localparam int DRAIN_MAX  = 5000;
  localparam int TAIL_TICKS = 8;

  // Where a stimulus byte comes from
  typedef enum int {FILL_NONE, FILL_CRC_LO, FILL_CRC_HI} byte_fill_e;
  // How a row's results are known
  typedef enum int {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_e;

  typedef struct {
    logic [7:0]    data;
    logic          cmd;
    logic          start;
    byte_fill_e    fill;
    row_check_e    check;
    crcfb_result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_value
  logic [1:0]  s_axis_tuser;   // [0] command, [1] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] out_byte, [23:8] crc_word
  logic [1:0]  m_axis_tuser;   // [0] byte_present, [1] crc_match
  logic        m_axis_tlast;   // frame_done

  // Framer state mirrored by the predictor; fr_crc holds high byte in 15:8
  logic [15:0] fr_crc;
  logic [3:0]  fr_pos;
  logic        fr_mode;
  logic [7:0]  fr_rx_lo;

  crcfb_result_t framer_out_q[$];
  crcfb_result_t step_out[$];
  stim_row_t     stim_table[$];

  int errors = 0;
  int send_idle_pct = 19;
  int recv_idle_pct = 78;
  int items_sent = 0;
  int results_checked = 0;
  int tx_frames = 0;
  int rx_checks = 0;
  int rx_good = 0;

  crc16_frame_builder_checker #(
    .TX_PAYLOAD_BYTES(TX_BYTES),
    .RX_PAYLOAD_BYTES(RX_BYTES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Reflected CCITT polynomial, one bit at a time (X.25 register order)
  function automatic logic [15:0] crc_x25_byte(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
    end
    return r;
  endfunction

  function automatic crcfb_result_t mk_result(input logic [7:0] b, input logic present,
                                              input logic done, input logic match,
                                              input logic [15:0] word);
    crcfb_result_t r;
    r.out_byte     = b;
    r.byte_present = present;
    r.frame_done   = done;
    r.crc_match    = match;
    r.crc_word     = word;
    return r;
  endfunction

  // Advance the mirrored framer by one input item; results land in step_out
  task automatic advance_framer(input logic [7:0] b, input logic cmd, input logic st);
    logic [15:0] w;
    step_out = {};
    if (st) begin
      fr_pos  = 4'd0;
      fr_crc  = 16'hFFFF;
      fr_mode = cmd;
    end
    if (fr_pos == POS_DONE) return;
    if (fr_mode == MODE_TX) begin
      fr_crc = crc_x25_byte(fr_crc, b);
      step_out.push_back(mk_result(b, 1'b1, 1'b0, 1'b0, 16'h0000));
      if (fr_pos + 1 >= TX_BYTES) begin
        w = ~fr_crc;
        step_out.push_back(mk_result(w[7:0], 1'b1, 1'b0, 1'b0, 16'h0000));
        step_out.push_back(mk_result(w[15:8], 1'b1, 1'b1, 1'b0, w));
        fr_pos = POS_DONE;
      end else begin
        fr_pos = fr_pos + 4'd1;
      end
    end else if (fr_pos < RX_BYTES) begin
      fr_crc = crc_x25_byte(fr_crc, b);
      fr_pos = fr_pos + 4'd1;
    end else if (fr_pos == RX_BYTES) begin
      fr_rx_lo = b;
      fr_pos   = fr_pos + 4'd1;
    end else begin
      w = ~fr_crc;
      step_out.push_back(mk_result(8'h00, 1'b0, 1'b1, {b, fr_rx_lo} == w, w));
      fr_pos = POS_DONE;
    end
  endtask

  // Offer one item, idling first at random, and hold it until accepted
  task automatic drive_byte(input logic [7:0] b, input logic cmd, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {st, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic void add_row(input logic [7:0] b, input logic cmd, input logic st,
                                  input byte_fill_e fill, input row_check_e check,
                                  input crcfb_result_t res);
    stim_row_t row;
    row.data  = b;
    row.cmd   = cmd;
    row.start = st;
    row.fill  = fill;
    row.check = check;
    row.res   = res;
    stim_table.push_back(row);
  endfunction

  // Transmit payload byte: echoed with byte_present only
  function automatic void row_tx_byte(input logic [7:0] b, input logic cmd, input logic st);
    add_row(b, cmd, st, FILL_NONE, CHK_ONE, mk_result(b, 1'b1, 1'b0, 1'b0, 16'h0000));
  endfunction

  // Byte that gives no result
  function automatic void row_silent(input logic [7:0] b, input logic cmd, input logic st);
    add_row(b, cmd, st, FILL_NONE, CHK_NONE, '0);
  endfunction

  function automatic void row_model(input logic [7:0] b, input logic cmd, input logic st,
                                    input byte_fill_e fill);
    add_row(b, cmd, st, fill, CHK_MODEL, '0);
  endfunction

  function automatic logic [7:0] fill_byte(input logic [7:0] b, input byte_fill_e fill);
    logic [15:0] w;
    w = ~fr_crc;
    case (fill)
      FILL_CRC_LO: return w[7:0];
      FILL_CRC_HI: return w[15:8];
      default:     return b;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Check each accepted result item against the oldest prediction; stall at random
  always @(posedge clk) begin
    crcfb_result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (framer_out_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result item, expected none, got data 0x%0h user %0b last %0b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        exp_r = framer_out_q.pop_front();
        results_checked++;
        check_field("out_byte", exp_r.out_byte, m_axis_tdata[7:0]);
        check_field("byte_present", exp_r.byte_present, m_axis_tuser[0]);
        check_field("frame_done", exp_r.frame_done, m_axis_tlast);
        check_field("crc_match", exp_r.crc_match, m_axis_tuser[1]);
        check_field("crc_word", exp_r.crc_word, m_axis_tdata[23:8]);
        if (exp_r.frame_done) begin
          if (exp_r.byte_present) tx_frames++;
          else begin
            rx_checks++;
            if (exp_r.crc_match) rx_good++;
          end
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Stimulus, prediction and end of run
  initial begin
    logic [7:0] b;
    logic       cmd;
    logic       st;
    int         rand_items;
    int         waited;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 2'b00;
    m_axis_tready = 1'b0;
    fr_crc   = 16'hFFFF;
    fr_pos   = 4'd0;
    fr_mode  = MODE_TX;
    fr_rx_lo = 8'h00;

    // No frame start after reset: transmit framing, command ignored
    row_tx_byte(8'h00, 1'b1, 1'b0);
    row_tx_byte(8'hFF, 1'b0, 1'b0);
    row_tx_byte(8'h80, 1'b1, 1'b0);
    row_tx_byte(8'h01, 1'b0, 1'b0);
    row_tx_byte(8'h55, 1'b0, 1'b0);
    row_tx_byte(8'hAA, 1'b1, 1'b0);
    row_tx_byte(8'h7F, 1'b0, 1'b0);
    row_model(8'hFE, 1'b1, 1'b0, FILL_NONE);
    // Byte after a complete frame is dropped
    row_silent(8'h5A, 1'b1, 1'b0);
    // Reply with a correct CRC
    row_silent(8'hFF, 1'b1, 1'b1);
    row_silent(8'h00, 1'b0, 1'b0);
    row_silent(8'h80, 1'b1, 1'b0);
    row_silent(8'h01, 1'b0, 1'b0);
    row_silent(8'h7F, 1'b0, 1'b0);
    row_silent(8'hC3, 1'b1, 1'b0);
    row_model(8'h00, 1'b0, 1'b0, FILL_CRC_LO);
    row_model(8'h00, 1'b1, 1'b0, FILL_CRC_HI);
    row_silent(8'h33, 1'b0, 1'b0);
    // Reply cut short by a transmit frame start, then a restart mid-frame
    row_silent(8'h12, 1'b1, 1'b1);
    row_silent(8'h34, 1'b1, 1'b0);
    row_tx_byte(8'hC0, 1'b0, 1'b1);
    row_tx_byte(8'h0F, 1'b0, 1'b0);
    row_tx_byte(8'hF0, 1'b0, 1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (stim_table[i]) begin
      b = fill_byte(stim_table[i].data, stim_table[i].fill);
      drive_byte(b, stim_table[i].cmd, stim_table[i].start);
      advance_framer(b, stim_table[i].cmd, stim_table[i].start);
      case (stim_table[i].check)
        CHK_MODEL: foreach (step_out[k]) framer_out_q.push_back(step_out[k]);
        CHK_ONE:   framer_out_q.push_back(stim_table[i].res);
        default:   ;
      endcase
    end

    // Random frames, mostly well formed, with restarts, bad CRCs and stray bytes
    rand_items = 0;
    while (rand_items < N_RANDOM) begin
      if (rand_items < N_RANDOM / 3) begin
        send_idle_pct = 19;
        recv_idle_pct = 78;
      end else if (rand_items < 2 * N_RANDOM / 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 19;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (fr_pos == POS_DONE) st = ($urandom_range(9) != 0);
      else st = ($urandom_range(24) == 0);
      cmd = 1'($urandom_range(1));
      b   = 8'($urandom_range(255));
      if (!st && fr_mode == MODE_RX && $urandom_range(4) != 0) begin
        if (fr_pos == RX_BYTES) b = fill_byte(b, FILL_CRC_LO);
        else if (fr_pos == RX_BYTES + 1) b = fill_byte(b, FILL_CRC_HI);
      end
      if (st || fr_pos != POS_DONE) rand_items++;
      drive_byte(b, cmd, st);
      advance_framer(b, cmd, st);
      foreach (step_out[k]) framer_out_q.push_back(step_out[k]);
    end
    s_axis_tvalid <= 1'b0;

    // Drain outstanding results
    waited = 0;
    while (framer_out_q.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (framer_out_q.size() != 0) begin
      $display("%0t ns: %0d result items never arrived", $time, framer_out_q.size());
      $display("Verification failed");
      $finish;
    end else begin
      repeat (TAIL_TICKS) @(posedge clk);
      $display("Sent %0d input items and checked %0d result items.", items_sent,
               results_checked);
      $display("Frames built: %0d; replies checked: %0d, %0d with a good CRC.", tx_frames,
               rx_checks, rx_good);
      if (errors == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
      $finish;
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("%0t ns: run timed out", $time);
    $display("Verification failed");
    $finish;
  end

endmodule
